### rtl/core/pidc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the multichannel PID controller: beat
// structs, field widths, gain layout and output limits.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int CH_W             = 2;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 48;

	localparam int SMP_W   = 16;
	localparam int ERR_W   = SMP_W + 1;
	localparam int SUM_W   = 32;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int GAIN_W  = 16;
	localparam int STATE_W = SUM_W + ERR_W;

	localparam int KP_LSB = 0;
	localparam int KI_LSB = 16;
	localparam int KD_LSB = 32;

	localparam int PROD_P_W = GAIN_W + ERR_W;
	localparam int PROD_I_W = GAIN_W + SUM_W;
	localparam int PROD_D_W = GAIN_W + DIFF_W;
	localparam int ACC_W    = PROD_I_W + 2;
	localparam int FRAC_SH  = 8;
	localparam int Q_W      = ACC_W - FRAC_SH;

	localparam int DRIVE_MAX = 25600;
	localparam int DRIVE_MIN = -32768;

	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic signed [SMP_W-1:0] setpoint;
		logic signed [SMP_W-1:0] feedback;
	} in_beat_t;

	typedef struct packed {
		logic [CH_W-1:0]         out_channel;
		logic signed [SMP_W-1:0] drive;
		logic                    clamped;
	} out_beat_t;

endpackage
`default_nettype wire

### rtl/core/pidc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pidc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/multichannel_pid_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_pid_controller_top
// Per-channel PID controller with saturating integrator and clamped output.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock while sample_stall is low and returns one
// result beat per sample, in order. After acceptance a sample passes the
// stage 1, stage 2, stage 3 and result registers; output stalls hold it.
// Integrator and previous error of each channel sit in a small state RAM that
// is read on acceptance and written back when the sample leaves stage 1. A
// forwarding register covers back-to-back samples on the same channel, and
// per-channel valid flags make the RAM read as zero after reset, so no
// clearing pass is needed. The three gain products are formed in their own
// stage, and the sum, shift and clamp in the next. Gains are to be written
// through the configuration port while the block is idle; it does not check.
// ----------------------------------------------------------------------------
module multichannel_pid_controller_top #(
	parameter int NUM_CHANNELS = pidc_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sample_valid,
	output logic                                sample_stall,
	input  wire pidc_pkg::in_beat_t             sample,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output pidc_pkg::out_beat_t                 result,
	input  wire logic                           cfg_wr_en,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pidc_pkg::*;

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [CFG_DATA_W-1:0] gains_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] seen_q;

	logic take, out_free, s3_free, s2_free, s1_free;

	logic                    valid_s1, inr_s1, seen_s1, byp_hit_s1;
	logic [CH_W-1:0]         ch_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic [STATE_W-1:0]      byp_data_s1;

	logic                     valid_s2, inr_s2;
	logic [CH_W-1:0]          ch_s2;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [GAIN_W-1:0] kp_s2, ki_s2, kd_s2;

	logic                       valid_s3, inr_s3;
	logic [CH_W-1:0]            ch_s3;
	logic signed [PROD_P_W-1:0] prod_p_s3;
	logic signed [PROD_I_W-1:0] prod_i_s3;
	logic signed [PROD_D_W-1:0] prod_d_s3;

	logic      result_valid_q;
	out_beat_t result_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr, rd_addr, addr_s1;
	logic [STATE_W-1:0] wr_data, rd_data, state_s1;
	logic              smp_inr;

	logic signed [SUM_W-1:0]  sum_old, sum_new;
	logic signed [ERR_W-1:0]  prev_err;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [DIFF_W-1:0] diff_s1;
	logic [CFG_DATA_W-1:0]    gains_s1;

	logic signed [ACC_W-1:0] acc;
	logic signed [Q_W-1:0]   q;
	out_beat_t               res_d;

	// handshake and stage advance
	assign out_free     = !result_valid_q || !result_stall;
	assign s3_free      = !valid_s3 || out_free;
	assign s2_free      = !valid_s2 || s3_free;
	assign s1_free      = !valid_s1 || s2_free;
	assign sample_stall = !s1_free;
	assign take         = sample_valid && s1_free;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign smp_inr = {1'b0, sample.channel} < (CH_W+1)'(NUM_CHANNELS);
	assign rd_addr = sample.channel[AW-1:0];
	assign addr_s1 = ch_s1[AW-1:0];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				gains_q[i] <= '0;
			end
		end else if (cfg_wr_en && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(NUM_CHANNELS))) begin
			gains_q[cfg_index[AW-1:0]] <= cfg_data;
		end
	end

	pidc_ram #(
		.WIDTH (STATE_W),
		.DEPTH (NUM_CHANNELS),
		.AW    (AW)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (take),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stage 1: read-modify-write of channel state
	always_comb begin
		if (byp_hit_s1) begin
			state_s1 = byp_data_s1;
		end else if (seen_s1) begin
			state_s1 = rd_data;
		end else begin
			state_s1 = '0;
		end
		sum_old  = state_s1[STATE_W-1 -: SUM_W];
		prev_err = state_s1[ERR_W-1:0];
		sum_wide = (SUM_W+1)'(sum_old) + (SUM_W+1)'(err_s1);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_new = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_new = sum_wide[SUM_W-1:0];
		end
		diff_s1  = DIFF_W'(err_s1) - DIFF_W'(prev_err);
		gains_s1 = gains_q[addr_s1];
	end

	assign wr_en   = valid_s1 && s2_free && inr_s1;
	assign wr_addr = addr_s1;
	assign wr_data = {sum_new, err_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (wr_en) begin
			seen_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1       <= sample.channel;
			inr_s1      <= smp_inr;
			err_s1      <= ERR_W'(sample.setpoint) - ERR_W'(sample.feedback);
			seen_s1     <= smp_inr && seen_q[rd_addr];
			byp_hit_s1  <= wr_en && (wr_addr == rd_addr);
			byp_data_s1 <= wr_data;
		end
	end

	// stage 2: operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_free) begin
			ch_s2   <= ch_s1;
			inr_s2  <= inr_s1;
			err_s2  <= err_s1;
			sum_s2  <= sum_new;
			diff_s2 <= diff_s1;
			kp_s2   <= gains_s1[KP_LSB +: GAIN_W];
			ki_s2   <= gains_s1[KI_LSB +: GAIN_W];
			kd_s2   <= gains_s1[KD_LSB +: GAIN_W];
		end
	end

	// stage 3: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && s3_free) begin
			ch_s3     <= ch_s2;
			inr_s3    <= inr_s2;
			prod_p_s3 <= PROD_P_W'(kp_s2 * err_s2);
			prod_i_s3 <= PROD_I_W'(ki_s2 * sum_s2);
			prod_d_s3 <= PROD_D_W'(kd_s2 * diff_s2);
		end
	end

	// sum, scale and clamp
	always_comb begin
		acc = ACC_W'(prod_p_s3) + ACC_W'(prod_i_s3) + ACC_W'(prod_d_s3);
		q   = Q_W'(acc >>> FRAC_SH);
		res_d.out_channel = ch_s3;
		res_d.drive       = '0;
		res_d.clamped     = 1'b0;
		if (inr_s3) begin
			if (q > Q_W'(DRIVE_MAX)) begin
				res_d.drive   = SMP_W'(DRIVE_MAX);
				res_d.clamped = 1'b1;
			end else if (q < Q_W'(DRIVE_MIN)) begin
				res_d.drive   = SMP_W'(DRIVE_MIN);
				res_d.clamped = 1'b1;
			end else begin
				res_d.drive = q[SMP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && out_free) begin
			result_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ({1'b0, result.out_channel} >= (CH_W+1)'(NUM_CHANNELS))
		|-> (result.drive == '0) && !result.clamped)
		else $error("out-of-range channel gave nonzero result");

	a_clamp_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.clamped
		|-> (result.drive == SMP_W'(DRIVE_MAX)) || (result.drive == SMP_W'(DRIVE_MIN)))
		else $error("clamp flag without drive at a limit");

	a_drive_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.drive <= SMP_W'(DRIVE_MAX)))
		else $error("drive above upper limit");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, ch_s1} < (CH_W+1)'(NUM_CHANNELS)))
		else $error("state write to channel out of range");
`endif

endmodule
`default_nettype wire
